@@ sv/gcn_pkg.sv @@
// ----------------------------------------------------------------------------
// gcn_pkg: shared types and constants of the gait cycle normalizer
// Sample and counter widths, the command passed from front to back, the
// result record, the divider control and the back-end state encoding.
// ----------------------------------------------------------------------------
package gcn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PERIOD  = 4096;
  localparam int CNT_W       = $clog2(MAX_PERIOD + 1);
  localparam int ACC_W       = SAMPLE_BITS + CNT_W;
  localparam int AMP_W       = SAMPLE_BITS - 1;
  localparam int DIV_CNT_W   = $clog2(ACC_W + 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // One classified item on its way to the back end
  typedef struct packed {
    logic                    close;
    logic signed [ACC_W-1:0] angle_acc;
    logic signed [ACC_W-1:0] vel_acc;
    logic [AMP_W-1:0]        angle_amp;
    logic [AMP_W-1:0]        vel_amp;
    logic [CNT_W-1:0]        count;
  } gcn_cmd_t;

  typedef struct packed {
    logic                          cycle_done;
    logic signed [SAMPLE_BITS-1:0] angle_mean;
    logic signed [SAMPLE_BITS-1:0] vel_mean;
    logic [AMP_W-1:0]              angle_amp;
    logic [AMP_W-1:0]              vel_amp;
    logic [CNT_W-1:0]              period_len;
  } gcn_res_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } gcn_div_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } gcn_state_e;

endpackage

@@ sv/gait_cycle_normalizer.sv @@
// ----------------------------------------------------------------------------
// gait_cycle_normalizer: per-cycle statistics of joint angle and velocity
// Accumulates both signals and, on each gait cycle close, latches the means,
// half-range amplitudes and period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive angle_sample_i / vel_sample_i and raise push_i; an
//   item is taken on a clock edge with push_i high and full_o low.
//   Result channel: while empty_o is low the oldest result sits on the result
//   ports; it is taken on a clock edge with pop_i high.
//   Every item yields exactly one result, in order.
//   Timing: with the back end idle, an item that does not close a cycle
//   passes through the command queue and the output register to the result
//   ports, and such items stream at one per cycle while pop_i stays high.
//   An item that closes a cycle waits on the serial divider, which produces
//   both means one quotient bit per cycle; the front keeps taking items into
//   the two-entry command queue meanwhile.
//   Reset clears all accumulators, the latched statistics and the queues.
//   A stalled receiver holds the output register; the queue then fills and
//   full_o rises, so no item is lost.
// ----------------------------------------------------------------------------
module gait_cycle_normalizer
  import gcn_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [SAMPLE_BITS-1:0] angle_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] vel_sample_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic                          cycle_done_o,
  output logic signed [SAMPLE_BITS-1:0] angle_mean_o,
  output logic signed [SAMPLE_BITS-1:0] vel_mean_o,
  output logic [AMP_W-1:0]              angle_amp_o,
  output logic [AMP_W-1:0]              vel_amp_o,
  output logic [CNT_W-1:0]              period_len_o
);

  logic                          accept;
  logic                          cmd_valid;
  gcn_cmd_t                      cmd_wr, cmd_rd;
  logic                          fifo_full, fifo_empty, fifo_pop;
  gcn_div_ctl_t                  div_ctl;
  logic                          div_busy, div_done;
  logic signed [SAMPLE_BITS-1:0] quo_a, quo_b;
  logic                          out_valid;
  gcn_res_t                      res;

  assign accept = push_i && !fifo_full;

  gcn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .angle_i     (angle_sample_i),
    .vel_i       (vel_sample_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  gcn_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_wr),
    .full_o    (fifo_full),
    .rd_en_i   (fifo_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (fifo_empty)
  );

  gcn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctl.start),
    .num_a_i (cmd_rd.angle_acc),
    .num_b_i (cmd_rd.vel_acc),
    .den_i   (cmd_rd.count),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b)
  );

  gcn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (cmd_rd),
    .fifo_pop_o   (fifo_pop),
    .div_ctl_o    (div_ctl),
    .div_busy_i   (div_busy),
    .div_done_i   (div_done),
    .quo_a_i      (quo_a),
    .quo_b_i      (quo_b),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop_i),
    .res_o        (res)
  );

  assign full_o       = fifo_full;
  assign empty_o      = !out_valid;
  assign cycle_done_o = res.cycle_done;
  assign angle_mean_o = res.angle_mean;
  assign vel_mean_o   = res.vel_mean;
  assign angle_amp_o  = res.angle_amp;
  assign vel_amp_o    = res.vel_amp;
  assign period_len_o = res.period_len;

  // a new division never starts over a running one
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_ctl.busy)
    else $error("divider started while busy");

  // a closed cycle always holds at least one sample
  a_closed_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && cycle_done_o) |-> (period_len_o != '0))
    else $error("closed cycle with zero period");

  // a finished division leads to a result on the result side
  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> ##2 !empty_o)
    else $error("closing result not presented");

  // the command queue only takes what it has room for
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_full && !fifo_pop) |=> !(fifo_empty))
    else $error("command queue lost an entry");

endmodule

@@ sv/gcn_front.sv @@
// ----------------------------------------------------------------------------
// gcn_front: item intake and cycle detection
// Classifies each accepted item as closing or accumulating, keeps the running
// sums and extremes, and pushes one command per item to the back end.
// ----------------------------------------------------------------------------
module gcn_front
  import gcn_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [SAMPLE_BITS-1:0] angle_i,
  input  logic signed [SAMPLE_BITS-1:0] vel_i,
  output logic                          cmd_valid_o,
  output gcn_cmd_t                      cmd_o
);

  logic signed [SAMPLE_BITS-1:0] prev_vel_q, prev_vel_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              last_period_q, last_period_d;
  logic signed [ACC_W-1:0]       angle_acc_q, angle_acc_d;
  logic signed [ACC_W-1:0]       vel_acc_q, vel_acc_d;
  logic signed [SAMPLE_BITS-1:0] angle_hi_q, angle_hi_d, angle_lo_q, angle_lo_d;
  logic signed [SAMPLE_BITS-1:0] vel_hi_q, vel_hi_d, vel_lo_q, vel_lo_d;
  logic                          close;
  logic [SAMPLE_BITS:0]          angle_span, vel_span;

  assign close = vel_i[SAMPLE_BITS-1]
              && !prev_vel_q[SAMPLE_BITS-1] && (prev_vel_q != '0)
              && ({count_q, 1'b0} > {1'b0, last_period_q});

  // extremes straddle zero, so the span is non-negative and fits SAMPLE_BITS
  assign angle_span = {angle_hi_q[SAMPLE_BITS-1], angle_hi_q}
                    - {angle_lo_q[SAMPLE_BITS-1], angle_lo_q};
  assign vel_span   = {vel_hi_q[SAMPLE_BITS-1], vel_hi_q}
                    - {vel_lo_q[SAMPLE_BITS-1], vel_lo_q};

  always_comb begin
    prev_vel_d    = prev_vel_q;
    count_d       = count_q;
    last_period_d = last_period_q;
    angle_acc_d   = angle_acc_q;
    vel_acc_d     = vel_acc_q;
    angle_hi_d    = angle_hi_q;
    angle_lo_d    = angle_lo_q;
    vel_hi_d      = vel_hi_q;
    vel_lo_d      = vel_lo_q;
    if (accept_i) begin
      prev_vel_d = vel_i;
      if (close) begin
        last_period_d = count_q;
        count_d       = '0;
        angle_acc_d   = '0;
        vel_acc_d     = '0;
        angle_hi_d    = '0;
        angle_lo_d    = '0;
        vel_hi_d      = '0;
        vel_lo_d      = '0;
      end else begin
        // freeze count and sums once saturated
        if (count_q < CNT_W'(MAX_PERIOD)) begin
          count_d     = count_q + CNT_W'(1);
          angle_acc_d = angle_acc_q
                      + {{(ACC_W-SAMPLE_BITS){angle_i[SAMPLE_BITS-1]}}, angle_i};
          vel_acc_d   = vel_acc_q
                      + {{(ACC_W-SAMPLE_BITS){vel_i[SAMPLE_BITS-1]}}, vel_i};
        end
        if (angle_i > angle_hi_q) angle_hi_d = angle_i;
        if (angle_i < angle_lo_q) angle_lo_d = angle_i;
        if (vel_i > vel_hi_q)     vel_hi_d   = vel_i;
        if (vel_i < vel_lo_q)     vel_lo_d   = vel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vel_q    <= '0;
      count_q       <= '0;
      last_period_q <= '0;
      angle_acc_q   <= '0;
      vel_acc_q     <= '0;
      angle_hi_q    <= '0;
      angle_lo_q    <= '0;
      vel_hi_q      <= '0;
      vel_lo_q      <= '0;
    end else begin
      prev_vel_q    <= prev_vel_d;
      count_q       <= count_d;
      last_period_q <= last_period_d;
      angle_acc_q   <= angle_acc_d;
      vel_acc_q     <= vel_acc_d;
      angle_hi_q    <= angle_hi_d;
      angle_lo_q    <= angle_lo_d;
      vel_hi_q      <= vel_hi_d;
      vel_lo_q      <= vel_lo_d;
    end
  end

  assign cmd_valid_o     = accept_i;
  assign cmd_o.close     = close;
  assign cmd_o.angle_acc = angle_acc_q;
  assign cmd_o.vel_acc   = vel_acc_q;
  assign cmd_o.angle_amp = angle_span[SAMPLE_BITS-1:1];
  assign cmd_o.vel_amp   = vel_span[SAMPLE_BITS-1:1];
  assign cmd_o.count     = count_q;

endmodule

@@ sv/gcn_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// gcn_cmd_fifo: short command queue between front and back
// Register-based FIFO; lets the front keep taking items while the back
// divides.
// ----------------------------------------------------------------------------
module gcn_cmd_fifo
  import gcn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_en_i,
  input  gcn_cmd_t wr_data_i,
  output logic     full_o,
  input  logic     rd_en_i,
  output gcn_cmd_t rd_data_o,
  output logic     empty_o
);

  gcn_cmd_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fill_q;

  assign full_o    = (fill_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (fill_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (wr_en_i) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (rd_en_i) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      case ({wr_en_i, rd_en_i})
        2'b10:   fill_q <= fill_q + FIFO_CNT_W'(1);
        2'b01:   fill_q <= fill_q - FIFO_CNT_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

@@ sv/gcn_div.sv @@
// ----------------------------------------------------------------------------
// gcn_div: two-lane serial divider for the cycle means
// Restoring division of both signed sums by the shared sample count, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module gcn_div
  import gcn_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ACC_W-1:0]       num_a_i,
  input  logic signed [ACC_W-1:0]       num_b_i,
  input  logic [CNT_W-1:0]              den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] quo_a_o,
  output logic signed [SAMPLE_BITS-1:0] quo_b_o
);

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [ACC_W-1:0] dvd;
  } lane_t;

  lane_t                lane_a_q, lane_a_d, lane_b_q, lane_b_d;
  logic                 neg_a_q, neg_b_q, zero_q;
  logic [CNT_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [ACC_W-1:0]     res_a, res_b;

  function automatic lane_t div_step(lane_t cur, logic [CNT_W-1:0] den);
    logic [CNT_W:0] shifted;
    lane_t          nxt;
    shifted = {cur.rem, cur.dvd[ACC_W-1]};
    if (shifted >= {1'b0, den}) begin
      nxt.rem = CNT_W'(shifted - {1'b0, den});
      nxt.dvd = {cur.dvd[ACC_W-2:0], 1'b1};
    end else begin
      nxt.rem = shifted[CNT_W-1:0];
      nxt.dvd = {cur.dvd[ACC_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic logic [ACC_W-1:0] magnitude(logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  always_comb begin
    lane_a_d = div_step(lane_a_q, den_q);
    lane_b_d = div_step(lane_b_q, den_q);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lane_a_q <= '{rem: '0, dvd: magnitude(num_a_i)};
      lane_b_q <= '{rem: '0, dvd: magnitude(num_b_i)};
      neg_a_q  <= num_a_i[ACC_W-1];
      neg_b_q  <= num_b_i[ACC_W-1];
      den_q    <= den_i;
      zero_q   <= (den_i == '0);
    end else if (busy_q) begin
      lane_a_q <= lane_a_d;
      lane_b_q <= lane_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_a   = neg_a_q ? ACC_W'(-lane_a_q.dvd) : lane_a_q.dvd;
  assign res_b   = neg_b_q ? ACC_W'(-lane_b_q.dvd) : lane_b_q.dvd;
  assign quo_a_o = zero_q ? '0 : res_a[SAMPLE_BITS-1:0];
  assign quo_b_o = zero_q ? '0 : res_b[SAMPLE_BITS-1:0];
  assign busy_o  = busy_q;
  assign done_o  = done_q;

endmodule

@@ sv/gcn_back.sv @@
// ----------------------------------------------------------------------------
// gcn_back: result generation
// Takes commands in order, runs the divider on closing items, keeps the
// latched cycle statistics and loads the output register.
// ----------------------------------------------------------------------------
module gcn_back
  import gcn_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fifo_empty_i,
  input  gcn_cmd_t                      cmd_i,
  output logic                          fifo_pop_o,
  output gcn_div_ctl_t                  div_ctl_o,
  input  logic                          div_busy_i,
  input  logic                          div_done_i,
  input  logic signed [SAMPLE_BITS-1:0] quo_a_i,
  input  logic signed [SAMPLE_BITS-1:0] quo_b_i,
  output logic                          out_valid_o,
  input  logic                          out_pop_i,
  output gcn_res_t                      res_o
);

  gcn_state_e                    state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] angle_mean_q, vel_mean_q;
  logic [AMP_W-1:0]              angle_amp_q, vel_amp_q, pend_angle_amp_q, pend_vel_amp_q;
  logic [CNT_W-1:0]              period_q, pend_period_q;
  gcn_res_t                      res_q;
  logic                          out_valid_q;
  logic                          slot_free;
  logic                          pop, div_start, load, load_done, upd;

  assign slot_free = !out_valid_q || out_pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!fifo_empty_i && cmd_i.close) state_d = ST_DIV;
      ST_DIV:  if (div_done_i) state_d = ST_EMIT;
      ST_EMIT: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    load_done = 1'b0;
    upd       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          if (cmd_i.close) begin
            pop       = 1'b1;
            div_start = 1'b1;
          end else if (slot_free) begin
            pop  = 1'b1;
            load = 1'b1;
          end
        end
      end
      ST_DIV:  upd = div_done_i;
      ST_EMIT: begin
        load      = slot_free;
        load_done = 1'b1;
      end
      default: ;
    endcase
  end

  // hold amplitudes and period until the means are ready
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      pend_angle_amp_q <= cmd_i.angle_amp;
      pend_vel_amp_q   <= cmd_i.vel_amp;
      pend_period_q    <= cmd_i.count;
    end
    if (load) begin
      res_q <= '{cycle_done: load_done, angle_mean: angle_mean_q, vel_mean: vel_mean_q,
                 angle_amp: angle_amp_q, vel_amp: vel_amp_q, period_len: period_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      angle_mean_q <= '0;
      vel_mean_q   <= '0;
      angle_amp_q  <= '0;
      vel_amp_q    <= '0;
      period_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load)           out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
      if (upd) begin
        angle_mean_q <= quo_a_i;
        vel_mean_q   <= quo_b_i;
        angle_amp_q  <= pend_angle_amp_q;
        vel_amp_q    <= pend_vel_amp_q;
        period_q     <= pend_period_q;
      end
    end
  end

  assign fifo_pop_o      = pop;
  assign div_ctl_o.start = div_start;
  assign div_ctl_o.busy  = div_busy_i;
  assign div_ctl_o.done  = div_done_i;
  assign out_valid_o     = out_valid_q;
  assign res_o           = res_q;

endmodule
